FILE: rtl/mrf_pkg.sv
// ----------------------------------------------------------------------------
// mrf_pkg
// Shared types, sizes and helpers for the message ring fifo.
// ----------------------------------------------------------------------------
package mrf_pkg;

	localparam int QUEUE_SLOTS = 8;
	localparam int MAX_BYTES   = 64;

	localparam int SLOT_W = $clog2(QUEUE_SLOTS);
	localparam int IDX_W  = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1;
	localparam int ADDR_W = $clog2(QUEUE_SLOTS * MAX_BYTES);

	// field widths of the ports
	localparam int ACT_W  = 2;
	localparam int BYTE_W = 8;
	localparam int LEN_W  = 7;
	localparam int STAT_W = 2;
	localparam int CNT_W  = 4;

	typedef enum logic [ACT_W-1:0] {
		ACT_POST  = 2'd0,
		ACT_PEND  = 2'd1,
		ACT_CLEAR = 2'd2
	} action_t;

	typedef enum logic [STAT_W-1:0] {
		STAT_OK        = 2'd0,
		STAT_FULL      = 2'd1,
		STAT_EMPTY     = 2'd2,
		STAT_TRUNCATED = 2'd3
	} status_t;

	// controller to datapath
	typedef struct packed {
		logic accept;      // input transaction taken
		logic load_status; // single status result goes to the output register
		logic pend_start;  // pop the head message and start reading it
		logic rd_en;       // read the next byte of the popped message
		logic load_byte;   // byte of the popped message goes to the output register
	} mrf_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic empty;
		logic rd_more;
		logic out_last;
	} mrf_stat_t;

	function automatic logic [ADDR_W-1:0] slot_addr(input logic [SLOT_W-1:0] slot,
			input logic [LEN_W-1:0] idx);
		logic [ADDR_W-1:0] base;
		base = ADDR_W'(slot) * ADDR_W'(MAX_BYTES);
		return base + ADDR_W'(idx);
	endfunction

endpackage

FILE: rtl/mrf_ctrl.sv
// ----------------------------------------------------------------------------
// mrf_ctrl
// Sequencer: takes transactions, streams popped messages, owns output valid.
// ----------------------------------------------------------------------------
module mrf_ctrl import mrf_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	input  logic [ACT_W-1:0] action,
	input  logic      last_byte,
	output logic      out_valid,
	input  logic      out_stall,
	output mrf_cmd_t  cmd,
	input  mrf_stat_t st
);

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_PEND = 2'b10
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   dv_q, dv_d;   // read data register holds an unsent byte
	logic   out_free;
	logic   load_any;

	assign out_free = !out_valid_q || !out_stall;

	always_comb begin
		cmd      = '0;
		state_d  = state_q;
		dv_d     = dv_q;
		in_stall = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				in_stall   = !out_free;
				cmd.accept = in_valid && out_free;
				if (cmd.accept) begin
					case (action_t'(action))
						ACT_POST: begin
							cmd.load_status = last_byte;
						end
						ACT_PEND: begin
							if (st.empty) begin
								cmd.load_status = 1'b1;
							end else begin
								cmd.pend_start = 1'b1;
								dv_d           = 1'b0;
								state_d        = ST_PEND;
							end
						end
						ACT_CLEAR: begin
							cmd.load_status = 1'b1;
						end
						default: begin
						end
					endcase
				end
			end
			ST_PEND: begin
				cmd.load_byte = dv_q && out_free;
				cmd.rd_en     = st.rd_more && (!dv_q || cmd.load_byte);
				if (cmd.rd_en) begin
					dv_d = 1'b1;
				end else if (cmd.load_byte) begin
					dv_d = 1'b0;
				end
				if (cmd.load_byte && st.out_last) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign load_any = cmd.load_status || cmd.load_byte;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			dv_q        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			dv_q    <= dv_d;
			if (load_any) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

FILE: rtl/mrf_dp.sv
// ----------------------------------------------------------------------------
// mrf_dp
// Datapath: message store, slot lengths, ring pointers, post tracking and
// the output register.
// ----------------------------------------------------------------------------
module mrf_dp import mrf_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  mrf_cmd_t          cmd,
	output mrf_stat_t         st,
	input  logic [ACT_W-1:0]  action,
	input  logic [BYTE_W-1:0] data_byte,
	input  logic              last_byte,
	output logic [BYTE_W-1:0] out_byte,
	output logic              last_of_run,
	output logic [LEN_W-1:0]  message_length,
	output logic [STAT_W-1:0] status,
	output logic [CNT_W-1:0]  queued_count
);

	logic [BYTE_W-1:0] mem [QUEUE_SLOTS*MAX_BYTES];
	logic [LEN_W-1:0]  slot_len_q [QUEUE_SLOTS];

	logic [SLOT_W-1:0] head_q, tail_q, pend_slot_q;
	logic [CNT_W-1:0]  count_q;
	logic [LEN_W-1:0]  wp_q;
	logic              rej_q, trunc_q;
	logic [LEN_W-1:0]  len_q, rd_idx_q;
	logic [IDX_W-1:0]  out_idx_q;
	logic [BYTE_W-1:0] rdata_q;

	logic [BYTE_W-1:0] out_byte_q;
	logic              out_last_q;
	logic [LEN_W-1:0]  out_len_q;
	logic [STAT_W-1:0] out_stat_q;
	logic [CNT_W-1:0]  out_cnt_q;

	logic              first;
	logic              rej_eff, trunc_eff, room;
	logic [SLOT_W:0]   tail_sum;
	logic [SLOT_W-1:0] tail_eff, head_inc;
	logic [LEN_W-1:0]  wp_new;
	logic              is_post, is_pend, is_clear, post_done, mem_we;
	logic [CNT_W-1:0]  count_new;
	logic [LEN_W-1:0]  res_len;
	status_t           res_stat;

	assign is_post  = cmd.accept && (action_t'(action) == ACT_POST);
	assign is_pend  = cmd.accept && (action_t'(action) == ACT_PEND);
	assign is_clear = cmd.accept && (action_t'(action) == ACT_CLEAR);

	// tail of a new post: (head + count) wrapped once
	assign tail_sum = (SLOT_W+1)'(head_q) + (SLOT_W+1)'(count_q);
	always_comb begin
		if (tail_sum >= (SLOT_W+1)'(QUEUE_SLOTS)) begin
			tail_eff = SLOT_W'(tail_sum - (SLOT_W+1)'(QUEUE_SLOTS));
		end else begin
			tail_eff = SLOT_W'(tail_sum);
		end
		if (!first) begin
			tail_eff = tail_q;
		end
	end

	assign head_inc = (head_q == SLOT_W'(QUEUE_SLOTS - 1)) ? '0 : head_q + 1'b1;

	assign first     = (wp_q == '0);
	assign room      = (wp_q < LEN_W'(MAX_BYTES));
	assign rej_eff   = first ? (count_q >= CNT_W'(QUEUE_SLOTS)) : rej_q;
	assign trunc_eff = !first && (trunc_q || !room);
	assign wp_new    = room ? wp_q + 1'b1 : wp_q;
	assign post_done = is_post && last_byte;
	assign mem_we    = is_post && room && !rej_eff;

	always_comb begin
		count_new = count_q;
		res_len   = '0;
		res_stat  = STAT_OK;
		if (is_clear) begin
			count_new = '0;
		end else if (is_pend) begin
			res_stat = STAT_EMPTY;
		end else if (post_done) begin
			res_len = wp_new;
			if (rej_eff) begin
				res_stat = STAT_FULL;
			end else begin
				count_new = count_q + 1'b1;
				res_stat  = trunc_eff ? STAT_TRUNCATED : STAT_OK;
			end
		end
	end

	assign st.empty    = (count_q == '0);
	assign st.rd_more  = (rd_idx_q != len_q);
	assign st.out_last = (LEN_W'(out_idx_q) + 1'b1 == len_q);

	// message store: writes while posting, reads while streaming a pend
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[slot_addr(tail_eff, wp_q)] <= data_byte;
		end
		if (cmd.rd_en) begin
			rdata_q <= mem[slot_addr(pend_slot_q, rd_idx_q)];
		end
	end

	always_ff @(posedge clk) begin
		if (post_done && !rej_eff) begin
			slot_len_q[tail_eff] <= wp_new;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			count_q <= '0;
			wp_q    <= '0;
			rej_q   <= 1'b0;
			trunc_q <= 1'b0;
			tail_q  <= '0;
		end else begin
			if (is_clear) begin
				head_q  <= '0;
				count_q <= '0;
				wp_q    <= '0;
				rej_q   <= 1'b0;
				trunc_q <= 1'b0;
				tail_q  <= '0;
			end else if (cmd.pend_start) begin
				head_q  <= head_inc;
				count_q <= count_q - 1'b1;
			end else if (is_post) begin
				count_q <= count_new;
				if (last_byte) begin
					wp_q    <= '0;
					rej_q   <= 1'b0;
					trunc_q <= 1'b0;
					tail_q  <= '0;
				end else begin
					wp_q    <= wp_new;
					rej_q   <= rej_eff;
					trunc_q <= trunc_eff;
					tail_q  <= tail_eff;
				end
			end
		end
	end

	// pend streaming counters
	always_ff @(posedge clk) begin
		if (cmd.pend_start) begin
			pend_slot_q <= head_q;
			len_q       <= slot_len_q[head_q];
			rd_idx_q    <= '0;
			out_idx_q   <= '0;
		end else begin
			if (cmd.rd_en) begin
				rd_idx_q <= rd_idx_q + 1'b1;
			end
			if (cmd.load_byte) begin
				out_idx_q <= out_idx_q + 1'b1;
			end
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (cmd.load_status) begin
			out_byte_q <= '0;
			out_last_q <= 1'b1;
			out_len_q  <= res_len;
			out_stat_q <= res_stat;
			out_cnt_q  <= count_new;
		end else if (cmd.load_byte) begin
			out_byte_q <= rdata_q;
			out_last_q <= st.out_last;
			out_len_q  <= len_q;
			out_stat_q <= STAT_OK;
			out_cnt_q  <= count_q;
		end
	end

	assign out_byte       = out_byte_q;
	assign last_of_run    = out_last_q;
	assign message_length = out_len_q;
	assign status         = out_stat_q;
	assign queued_count   = out_cnt_q;

endmodule

FILE: rtl/message_ring_fifo.sv
// ----------------------------------------------------------------------------
// message_ring_fifo
// Ring queue of whole messages with byte-wise post and pend.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_stall) carries action, data_byte, last_byte.
// A post transaction writes one byte into the tail slot; only the byte
// marked last gives a result (status ok, full or truncated, with length).
// A pend transaction pops the head message and returns one result per byte
// with last_of_run on the final one, or a single empty result. Clear gives
// one result and drops every message and any open post.
// Output channel (out_valid/out_stall) presents results from an output
// register; every result carries the message count after the transaction.
// A status result appears in the cycle after its transaction. A pend pops
// the head message, reads the first byte from the store, then delivers
// one byte per cycle while the receiver does not stall; the input stalls
// until the last byte is in the output register. Posts and clears take
// one transaction per cycle while the output register is free or draining.
// A stalled receiver holds the output register; new transactions wait
// while it is full and not draining. The store is single ported.
// Reset empties the queue and closes any open post; no clearing pass.
// ----------------------------------------------------------------------------
module message_ring_fifo import mrf_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [ACT_W-1:0]  action,
	input  logic [BYTE_W-1:0] data_byte,
	input  logic              last_byte,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [BYTE_W-1:0] out_byte,
	output logic              last_of_run,
	output logic [LEN_W-1:0]  message_length,
	output logic [STAT_W-1:0] status,
	output logic [CNT_W-1:0]  queued_count
);

	mrf_cmd_t  cmd;
	mrf_stat_t st;

	mrf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.action    (action),
		.last_byte (last_byte),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd),
		.st        (st)
	);

	mrf_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.st             (st),
		.action         (action),
		.data_byte      (data_byte),
		.last_byte      (last_byte),
		.out_byte       (out_byte),
		.last_of_run    (last_of_run),
		.message_length (message_length),
		.status         (status),
		.queued_count   (queued_count)
	);

endmodule
